// ===== hdl/wsp_pkg.sv =====
// ----------------------------------------------------------------------------
// World-to-screen projection package
// Shared widths, codes and pipeline types of the projection block.
// ----------------------------------------------------------------------------
package wsp_pkg;

	localparam int CLIP_W    = 50;
	localparam int Q_BITS    = 33;
	localparam int FRAC_BITS = 16;
	localparam int MAG_W     = 63;
	localparam int FAC_W     = 15;
	localparam int CFG_W     = 14;
	localparam int HALF_W    = 13;

	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_PROJECT = 1'b1;

	localparam logic REG_SCREEN_WIDTH  = 1'b0;
	localparam logic REG_SCREEN_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 14'd1920;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 14'd1080;

	localparam logic signed [CLIP_W-1:0] W_MIN = 50'sd65;

	localparam int CLIP_LAT = 3;
	localparam int AXIS_LAT = Q_BITS + 5;
	localparam int PIPE_LAT = CLIP_LAT + AXIS_LAT;

	typedef struct packed {
		logic signed [CLIP_W-1:0] x;
		logic signed [CLIP_W-1:0] y;
		logic signed [CLIP_W-1:0] w;
	} clip_t;

	typedef struct packed {
		logic [CLIP_W-1:0] rem;
		logic [Q_BITS-1:0] dvd;
		logic [Q_BITS-1:0] quo;
		logic [CLIP_W-1:0] den;
		logic              neg;
		logic              ovf;
	} div_t;

endpackage

// ===== hdl/wsp_in_if.sv =====
// ----------------------------------------------------------------------------
// Point channel
// Carries load and project transactions into the projection block.
// ----------------------------------------------------------------------------
interface wsp_in_if;
	logic               valid;
	logic               ready;
	logic               mode;
	logic [3:0]         coeff_index;
	logic signed [31:0] coeff_value;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;

	modport source (output valid, mode, coeff_index, coeff_value, pos_x, pos_y, pos_z,
		input ready);
	modport sink (input valid, mode, coeff_index, coeff_value, pos_x, pos_y, pos_z,
		output ready);
endinterface

// ===== hdl/wsp_out_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Carries one screen position transaction for each projected point.
// ----------------------------------------------------------------------------
interface wsp_out_if;
	logic               valid;
	logic               ready;
	logic               visible;
	logic signed [31:0] screen_x;
	logic signed [31:0] screen_y;

	modport source (output valid, visible, screen_x, screen_y, input ready);
	modport sink (input valid, visible, screen_x, screen_y, output ready);
endinterface

// ===== hdl/world_to_screen_projection_top.sv =====
// Each accepted project transaction gives one result via the clip and axis stages.
// Throughput: one transaction per cycle; the pipeline holds while the result stalls.
// Load transactions write the matrix at once and produce no result.
// Reset clears the matrix and valid bits and sets the screen size to 1920 by 1080.
// ----------------------------------------------------------------------------
// World-to-screen projection top level
// Configuration registers, valid pipeline and the clip and axis datapaths.
// ----------------------------------------------------------------------------
module world_to_screen_projection_top
	import wsp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	wsp_in_if.sink           points,
	wsp_out_if.source        results
);

	logic [CFG_W-1:0]        width_q, height_q;
	logic                    vld_s [1:PIPE_LAT];
	logic                    vis_s [CLIP_LAT+1:PIPE_LAT];
	logic                    en;
	clip_t                   clip;
	logic [HALF_W-1:0]       hw, hh;
	logic signed [FAC_W-1:0] fac_x, fac_y;
	logic signed [31:0]      rx, ry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH:  width_q  <= cfg_wdata;
				REG_SCREEN_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign en            = !vld_s[PIPE_LAT] || results.ready;
	assign points.ready  = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= PIPE_LAT; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= points.valid && (points.mode == MODE_PROJECT);
			for (int i = 2; i <= PIPE_LAT; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vis_s[CLIP_LAT+1] <= clip.w > W_MIN;
			for (int i = CLIP_LAT + 2; i <= PIPE_LAT; i++) vis_s[i] <= vis_s[i-1];
		end
	end

	wsp_clip u_clip (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ld     (points.valid && en && (points.mode == MODE_LOAD)),
		.ld_idx (points.coeff_index),
		.ld_val (points.coeff_value),
		.px     (points.pos_x),
		.py     (points.pos_y),
		.pz     (points.pos_z),
		.clip   (clip)
	);

	assign hw    = width_q[CFG_W-1:1];
	assign hh    = height_q[CFG_W-1:1];
	assign fac_x = $signed({2'b0, hw}) + 15'sd1;
	assign fac_y = 15'sd1 - $signed({2'b0, hh});

	wsp_axis u_axis_x (
		.clk  (clk),
		.en   (en),
		.c    (clip.x),
		.w    (clip.w),
		.fac  (fac_x),
		.half (hw),
		.res  (rx)
	);

	wsp_axis u_axis_y (
		.clk  (clk),
		.en   (en),
		.c    (clip.y),
		.w    (clip.w),
		.fac  (fac_y),
		.half (hh),
		.res  (ry)
	);

	assign results.valid    = vld_s[PIPE_LAT];
	assign results.visible  = vis_s[PIPE_LAT];
	assign results.screen_x = vis_s[PIPE_LAT] ? rx : 32'sd0;
	assign results.screen_y = vis_s[PIPE_LAT] ? ry : 32'sd0;

endmodule

// ===== hdl/wsp_clip.sv =====
// ----------------------------------------------------------------------------
// Clip transform
// Holds the matrix and computes clip x, y and w in three pipeline stages.
// ----------------------------------------------------------------------------
module wsp_clip
	import wsp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               ld,
	input  logic [3:0]         ld_idx,
	input  logic signed [31:0] ld_val,
	input  logic signed [31:0] px,
	input  logic signed [31:0] py,
	input  logic signed [31:0] pz,
	output clip_t              clip
);

	logic signed [31:0] mat_q [16];
	logic signed [31:0] pos_s1 [3];
	logic signed [31:0] cf_s1 [3][4];
	logic signed [47:0] prd_s2 [3][3];
	logic signed [31:0] cst_s2 [3];
	logic signed [63:0] full [3][3];
	logic signed [CLIP_W-1:0] sum [3];
	clip_t clip_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) mat_q[i] <= '0;
		end else if (ld) begin
			mat_q[ld_idx] <= ld_val;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1[0] <= px;
			pos_s1[1] <= py;
			pos_s1[2] <= pz;
			for (int c = 0; c < 4; c++) begin
				cf_s1[0][c] <= mat_q[c];
				cf_s1[1][c] <= mat_q[4 + c];
				cf_s1[2][c] <= mat_q[12 + c];
			end
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) full[r][c] = pos_s1[c] * cf_s1[r][c];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) prd_s2[r][c] <= full[r][c][63:16];
				cst_s2[r] <= cf_s1[r][3];
			end
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum[r] = CLIP_W'(prd_s2[r][0]) + CLIP_W'(prd_s2[r][1])
				+ CLIP_W'(prd_s2[r][2]) + CLIP_W'(cst_s2[r]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			clip_s3.x <= sum[0];
			clip_s3.y <= sum[1];
			clip_s3.w <= sum[2];
		end
	end

	assign clip = clip_s3;

endmodule

// ===== hdl/wsp_div_step.sv =====
// ----------------------------------------------------------------------------
// Divider step
// One registered restoring division step that yields one quotient bit.
// ----------------------------------------------------------------------------
module wsp_div_step
	import wsp_pkg::*;
(
	input  logic clk,
	input  logic en,
	input  div_t din,
	output div_t dout
);

	logic [CLIP_W:0] t;
	logic [CLIP_W:0] diff;
	logic            ge;
	div_t            step_s;

	assign t    = {din.rem, din.dvd[Q_BITS-1]};
	assign diff = t - {1'b0, din.den};
	assign ge   = t >= {1'b0, din.den};

	always_ff @(posedge clk) begin
		if (en) begin
			step_s.rem <= ge ? diff[CLIP_W-1:0] : t[CLIP_W-1:0];
			step_s.dvd <= {din.dvd[Q_BITS-2:0], 1'b0};
			step_s.quo <= {din.quo[Q_BITS-2:0], ge};
			step_s.den <= din.den;
			step_s.neg <= din.neg;
			step_s.ovf <= din.ovf;
		end
	end

	assign dout = step_s;

endmodule

// ===== hdl/wsp_axis.sv =====
// ----------------------------------------------------------------------------
// Axis mapping
// Scales a clip coordinate, divides by w, adds the viewport offset, clamps.
// ----------------------------------------------------------------------------
module wsp_axis
	import wsp_pkg::*;
(
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [CLIP_W-1:0] c,
	input  logic signed [CLIP_W-1:0] w,
	input  logic signed [FAC_W-1:0]  fac,
	input  logic [HALF_W-1:0]        half,
	output logic signed [31:0]       res
);

	logic signed [40:0]       plo_s1;
	logic signed [39:0]       phi_s1;
	logic [CLIP_W-1:0]        den_s1, den_s2, den_s3;
	logic signed [63:0]       prod_s2;
	logic [MAG_W-1:0]         mag_s3;
	logic                     neg_s3;
	div_t                     chain [Q_BITS+1];
	div_t                     init_s4;
	logic [Q_BITS:0]          f;
	logic signed [Q_BITS+1:0] val;
	logic signed [Q_BITS+2:0] total;
	logic signed [31:0]       res_s;

	always_ff @(posedge clk) begin
		if (en) begin
			plo_s1  <= fac * $signed({1'b0, c[24:0]});
			phi_s1  <= fac * $signed(c[CLIP_W-1:25]);
			den_s1  <= w;
			prod_s2 <= (64'(phi_s1) <<< 25) + 64'(plo_s1);
			den_s2  <= den_s1;
			neg_s3  <= prod_s2[63];
			mag_s3  <= prod_s2[63] ? MAG_W'(-prod_s2) : prod_s2[MAG_W-1:0];
			den_s3  <= den_s2;
			init_s4.ovf <= {4'b0, mag_s3} >= {den_s3, 17'b0};
			init_s4.rem <= {4'b0, mag_s3[MAG_W-1:17]};
			init_s4.dvd <= {mag_s3[16:0], 16'b0};
			init_s4.quo <= '0;
			init_s4.den <= den_s3;
			init_s4.neg <= neg_s3;
		end
	end

	assign chain[0] = init_s4;

	for (genvar i = 0; i < Q_BITS; i++) begin : g_div
		wsp_div_step u_step (
			.clk  (clk),
			.en   (en),
			.din  (chain[i]),
			.dout (chain[i+1])
		);
	end

	always_comb begin
		f     = chain[Q_BITS].ovf ? {1'b1, {Q_BITS{1'b0}}} : {1'b0, chain[Q_BITS].quo};
		val   = chain[Q_BITS].neg ? -$signed({1'b0, f}) : $signed({1'b0, f});
		total = (Q_BITS+3)'(val) + $signed({4'b0, half, 16'b0});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (total > 36'sh0_7FFF_FFFF) begin
				res_s <= 32'sh7FFF_FFFF;
			end else if (total < -36'sh0_8000_0000) begin
				res_s <= -32'sh8000_0000;
			end else begin
				res_s <= total[31:0];
			end
		end
	end

	assign res = res_s;

endmodule

// ===== tb/world_to_screen_projection_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// World-to-screen projection testbench
// Loads view matrices and projects points through the block under bursty input
// and a stalling result side. A local copy of the matrix and screen size
// predicts each screen position. Results are compared field by field in order.
// Screen-size settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module world_to_screen_projection_top_tb;
	import wsp_pkg::*;

	typedef struct {
		logic               mode;
		logic [3:0]         idx;
		logic signed [31:0] cv;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} point_req_t;

	typedef struct {
		logic               visible;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
	} screen_pos_t;

	typedef struct {
		logic               mode;
		logic [3:0]         idx;
		logic signed [31:0] cv;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		bit                 typed;
		logic               visible;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
	} directed_row_t;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int N_DIRECTED = 20;
	localparam logic signed [31:0] ONE = 32'sh0001_0000;
	localparam logic signed [31:0] SMAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] SMIN = 32'sh8000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_SCREEN_WIDTH;
	logic [CFG_W-1:0] cfg_wdata = '0;

	wsp_in_if points();
	wsp_out_if results();

	world_to_screen_projection_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.points(points),
		.results(results)
	);

	logic signed [31:0] view_mat[16];
	logic [CFG_W-1:0] width_reg = WIDTH_RESET;
	logic [CFG_W-1:0] height_reg = HEIGHT_RESET;
	screen_pos_t pending_pos[$];
	int mismatches = 0;
	int idle_cycles = 0;
	int burst_left = 0;

	directed_row_t directed_rows[N_DIRECTED] = '{
		'{MODE_PROJECT, 4'd0, 0, 0, 0, 0, 1, 1'b0, 0, 0},
		'{MODE_PROJECT, 4'd15, SMIN, SMAX, SMAX, SMAX, 1, 1'b0, 0, 0},
		'{MODE_LOAD, 4'd15, ONE, 0, 0, 0, 0, 1'b0, 0, 0},
		'{MODE_LOAD, 4'd0, ONE, 0, 0, 0, 0, 1'b0, 0, 0},
		'{MODE_LOAD, 4'd5, ONE, 0, 0, 0, 0, 1'b0, 0, 0},
		'{MODE_PROJECT, 4'd0, 0, 0, 0, 0, 1, 1'b1, 32'sd960 * 65536, 32'sd540 * 65536},
		'{MODE_PROJECT, 4'd0, 0, ONE, ONE, 0, 0, 1'b0, 0, 0},
		'{MODE_PROJECT, 4'd0, 0, -ONE, -ONE, ONE, 0, 1'b0, 0, 0},
		'{MODE_LOAD, 4'd15, 32'sd65, 0, 0, 0, 0, 1'b0, 0, 0},
		'{MODE_PROJECT, 4'd0, 0, 0, 0, 0, 1, 1'b0, 0, 0},
		'{MODE_LOAD, 4'd15, 32'sd66, 0, 0, 0, 0, 1'b0, 0, 0},
		'{MODE_PROJECT, 4'd0, 0, 32'sd7, -32'sd3, 0, 0, 1'b0, 0, 0},
		'{MODE_PROJECT, 4'd0, 0, SMAX, SMIN, 0, 0, 1'b0, 0, 0},
		'{MODE_LOAD, 4'd15, -ONE, 0, 0, 0, 0, 1'b0, 0, 0},
		'{MODE_PROJECT, 4'd0, 0, ONE, ONE, ONE, 1, 1'b0, 0, 0},
		'{MODE_LOAD, 4'd14, SMAX, 0, 0, 0, 0, 1'b0, 0, 0},
		'{MODE_PROJECT, 4'd0, 0, ONE, 0, SMAX, 0, 1'b0, 0, 0},
		'{MODE_PROJECT, 4'd0, 0, 0, ONE, SMIN, 0, 1'b0, 0, 0},
		'{MODE_LOAD, 4'd12, SMIN, 0, 0, 0, 0, 1'b0, 0, 0},
		'{MODE_PROJECT, 4'd0, 0, SMIN, SMAX, ONE, 0, 1'b0, 0, 0}
	};

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint clip_of(int r, longint x, longint y, longint z);
		longint acc;
		longint c0, c1, c2, c3;
		c0 = view_mat[r * 4];
		c1 = view_mat[r * 4 + 1];
		c2 = view_mat[r * 4 + 2];
		c3 = view_mat[r * 4 + 3];
		acc = ((x * c0) >>> 16) + ((y * c1) >>> 16) + ((z * c2) >>> 16) + c3;
		return acc;
	endfunction

	function automatic logic signed [31:0] axis_to_screen(longint clip, longint fac,
			longint half, longint w);
		longint prod, val;
		bit neg;
		longint unsigned mag, den, q, r, f;
		prod = fac * clip;
		neg = prod < 0;
		mag = neg ? longint'(0) - prod : prod;
		den = w;
		q = mag / den;
		r = mag % den;
		if (q >= (64'd1 << 20)) begin
			f = 64'd1 << 36;
		end else begin
			f = q;
			for (int i = 0; i < 16; i++) begin
				r = r << 1;
				f = f << 1;
				if (r >= den) begin
					r = r - den;
					f = f | 64'd1;
				end
			end
		end
		val = neg ? -longint'(f) : longint'(f);
		val = val + half * 65536;
		if (val > longint'(SMAX))
			val = SMAX;
		if (val < longint'(SMIN))
			val = SMIN;
		return val[31:0];
	endfunction

	function automatic screen_pos_t project_point(point_req_t p);
		screen_pos_t s;
		longint x, y, z, w, hw, hh;
		x = p.x;
		y = p.y;
		z = p.z;
		w = clip_of(3, x, y, z);
		s = '{1'b0, 0, 0};
		if (w > 65) begin
			hw = width_reg / 2;
			hh = height_reg / 2;
			s.visible = 1'b1;
			s.sx = axis_to_screen(clip_of(0, x, y, z), hw + 1, hw, w);
			s.sy = axis_to_screen(clip_of(1, x, y, z), 1 - hh, hh, w);
		end
		return s;
	endfunction

	task automatic send_point(point_req_t p, bit typed, screen_pos_t typed_pos);
		screen_pos_t s;
		if (burst_left == 0) begin
			points.valid <= 1'b0;
			repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0) @(negedge clk);
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		points.valid <= 1'b1;
		points.mode <= p.mode;
		points.coeff_index <= p.idx;
		points.coeff_value <= p.cv;
		points.pos_x <= p.x;
		points.pos_y <= p.y;
		points.pos_z <= p.z;
		do @(posedge clk); while (!points.ready);
		if (p.mode == MODE_LOAD) begin
			view_mat[p.idx] = p.cv;
		end else begin
			s = project_point(p);
			if (typed && (s.visible !== typed_pos.visible || s.sx !== typed_pos.sx
					|| s.sy !== typed_pos.sy))
				$display("note: table entry differs from prediction at %0t", $realtime);
			pending_pos.push_back(typed ? typed_pos : s);
		end
		@(negedge clk);
	endtask

	task automatic drain_and_wait();
		points.valid <= 1'b0;
		burst_left = 0;
		while (pending_pos.size() != 0) @(negedge clk);
		repeat (PIPE_LAT + 6) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SCREEN_WIDTH)
			width_reg = value;
		else
			height_reg = value;
	endtask

	function automatic logic signed [31:0] pick_value(bit scaled);
		case ($urandom_range(0, 9))
			0: return SMAX;
			1: return SMIN;
			2: return 0;
			3, 4: return $urandom;
			default: return scaled ? $signed($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000
				: $signed($urandom_range(0, 32'h7f_ffff)) - 32'sh40_0000;
		endcase
	endfunction

	function automatic point_req_t random_point(logic mode, logic [3:0] idx, bit scaled);
		point_req_t p;
		p.mode = mode;
		p.idx = idx;
		p.cv = pick_value(scaled);
		p.x = pick_value(scaled);
		p.y = pick_value(scaled);
		p.z = pick_value(scaled);
		if (mode == MODE_LOAD && idx == 4'd15 && $urandom_range(0, 2) != 0)
			p.cv = $urandom_range(1, 32'h8_0000);
		return p;
	endfunction

	task automatic random_phase(int n_items);
		int sent;
		point_req_t p;
		screen_pos_t none;
		sent = 0;
		none = '{1'b0, 0, 0};
		while (sent < n_items) begin
			if ($urandom_range(0, 4) != 0) begin
				for (int k = 0; k < 16; k++) begin
					send_point(random_point(MODE_LOAD, k[3:0], 1'b1), 1'b0, none);
				end
				sent += 16;
				repeat ($urandom_range(4, 16)) begin
					send_point(random_point(MODE_PROJECT, 4'($urandom), 1'b1), 1'b0, none);
					sent++;
				end
			end else begin
				p = random_point(1'($urandom), 4'($urandom), 1'b0);
				send_point(p, 1'b0, none);
				sent++;
			end
		end
	endtask

	// Result side stalls in runs with occasional stretches of full acceptance.
	initial begin
		int mode_left, duty;
		results.ready = 1'b0;
		mode_left = 0;
		duty = 100;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode_left = $urandom_range(20, 200);
				duty = $urandom_range(0, 2) == 0 ? 100 : $urandom_range(10, 90);
			end
			mode_left--;
			results.ready <= $urandom_range(1, 100) <= duty;
		end
	end

	always @(posedge clk) begin
		screen_pos_t e;
		if (results.valid && results.ready) begin
			if (pending_pos.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction: visible %0b x %0d y %0d",
						results.visible, results.screen_x, results.screen_y);
			end else begin
				e = pending_pos.pop_front();
				if (results.visible !== e.visible || results.screen_x !== e.sx
						|| results.screen_y !== e.sy) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0b %0d %0d, got %0b %0d %0d",
							e.visible, e.sx, e.sy, results.visible,
							results.screen_x, results.screen_y);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((points.valid && points.ready) || (results.valid && results.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		point_req_t p;
		screen_pos_t s;
		directed_row_t row;
		points.valid = 1'b0;
		points.mode = MODE_LOAD;
		points.coeff_index = '0;
		points.coeff_value = '0;
		points.pos_x = '0;
		points.pos_y = '0;
		points.pos_z = '0;
		foreach (view_mat[i]) view_mat[i] = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			p = '{row.mode, row.idx, row.cv, row.x, row.y, row.z};
			s = '{row.visible, row.sx, row.sy};
			send_point(p, row.typed, s);
		end
		random_phase(150);
		drain_and_wait();

		write_reg(REG_SCREEN_WIDTH, 14'd0);
		write_reg(REG_SCREEN_HEIGHT, 14'd0);
		random_phase(150);
		drain_and_wait();

		write_reg(REG_SCREEN_WIDTH, 14'h3fff);
		write_reg(REG_SCREEN_HEIGHT, 14'h3fff);
		random_phase(200);
		drain_and_wait();

		write_reg(REG_SCREEN_WIDTH, 14'd1);
		write_reg(REG_SCREEN_HEIGHT, 14'd8192);
		random_phase(200);
		drain_and_wait();

		write_reg(REG_SCREEN_WIDTH, CFG_W'($urandom_range(1, 8192)));
		write_reg(REG_SCREEN_HEIGHT, CFG_W'($urandom_range(1, 8192)));
		random_phase(230);
		drain_and_wait();

		if (pending_pos.size() != 0)
			mismatches += pending_pos.size();
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
